// ===== sv/eight_bit_cpu_instruction_step_unit_defines.svh =====
// Assertion macros used by the checker file of the instruction step unit.
`ifndef EIGHT_BIT_CPU_INSTRUCTION_STEP_UNIT_DEFINES_SVH
`define EIGHT_BIT_CPU_INSTRUCTION_STEP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EBCPU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EBCPU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ebcpu_pkg.sv =====
`default_nettype none
package ebcpu_pkg;

	localparam logic [15:0] IO_PAGE   = 16'hFF00;
	localparam logic [7:0]  PREFIX_CB = 8'hCB;
	localparam logic [7:0]  CB_RL_C   = 8'h11;
	localparam logic [7:0]  CB_BIT7_H = 8'h7C;
	localparam logic [7:0]  BYTE_MASK = 8'hFF;

	// Primary opcodes of the supported subset.
	localparam logic [7:0] OP_NOP      = 8'h00;
	localparam logic [7:0] OP_LD_BC_NN = 8'h01;
	localparam logic [7:0] OP_DEC_B    = 8'h05;
	localparam logic [7:0] OP_LD_B_N   = 8'h06;
	localparam logic [7:0] OP_INC_C    = 8'h0C;
	localparam logic [7:0] OP_DEC_C    = 8'h0D;
	localparam logic [7:0] OP_LD_C_N   = 8'h0E;
	localparam logic [7:0] OP_LD_DE_NN = 8'h11;
	localparam logic [7:0] OP_RLA      = 8'h17;
	localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
	localparam logic [7:0] OP_JR_NZ    = 8'h20;
	localparam logic [7:0] OP_LD_HL_NN = 8'h21;
	localparam logic [7:0] OP_LDI_HL_A = 8'h22;
	localparam logic [7:0] OP_INC_HL   = 8'h23;
	localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
	localparam logic [7:0] OP_LD_SP_NN = 8'h31;
	localparam logic [7:0] OP_LDD_HL_A = 8'h32;
	localparam logic [7:0] OP_LD_HL_N  = 8'h36;
	localparam logic [7:0] OP_LD_A_N   = 8'h3E;
	localparam logic [7:0] OP_LD_C_A   = 8'h4F;
	localparam logic [7:0] OP_LD_HL_A  = 8'h77;
	localparam logic [7:0] OP_XOR_A    = 8'hAF;
	localparam logic [7:0] OP_POP_BC   = 8'hC1;
	localparam logic [7:0] OP_JP_NN    = 8'hC3;
	localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
	localparam logic [7:0] OP_RET      = 8'hC9;
	localparam logic [7:0] OP_CALL_NN  = 8'hCD;
	localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
	localparam logic [7:0] OP_LD_IOC_A = 8'hE2;
	localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
	localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
	localparam logic [7:0] OP_DI       = 8'hF3;
	localparam logic [7:0] OP_CP_N     = 8'hFE;

	// Memory request kinds.
	localparam logic [2:0] MK_NONE = 3'd0;
	localparam logic [2:0] MK_RB   = 3'd1;
	localparam logic [2:0] MK_WB   = 3'd2;
	localparam logic [2:0] MK_RW   = 3'd3;
	localparam logic [2:0] MK_WW   = 3'd4;

	// Step status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_OP  = 2'd1;
	localparam logic [1:0] ST_BAD_CB  = 2'd2;
	localparam logic [1:0] ST_SEQ_ERR = 2'd3;

	// Beat kinds on the item channel.
	localparam logic ACT_EXEC    = 1'b0;
	localparam logic ACT_DELIVER = 1'b1;

	// Destination of an outstanding read.
	typedef enum logic [1:0] {
		PL_NONE = 2'd0,
		PL_ACC  = 2'd1,
		PL_BC   = 2'd2,
		PL_PC   = 2'd3
	} pend_t;

	// Architectural state; flags are {Z, N, H, C}.
	typedef struct packed {
		logic [7:0]  acc;
		logic [3:0]  flags;
		logic [15:0] bc;
		logic [15:0] de;
		logic [15:0] hl;
		logic [15:0] sp;
		logic [15:0] pc;
		logic        ie_off;
		pend_t       pend;
	} state_t;

	// Per-step result apart from the architectural state.
	typedef struct packed {
		logic [2:0]  mem_kind;
		logic [15:0] mem_address;
		logic [15:0] mem_write_data;
		logic [4:0]  cycles;
		logic [1:0]  status;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/ebcpu_exec.sv =====
`default_nettype none
module ebcpu_exec (
	input  ebcpu_pkg::state_t  cur,
	input  logic               action,
	input  logic [7:0]         opcode,
	input  logic [7:0]         operand_low,
	input  logic [7:0]         operand_high,
	input  logic [15:0]        read_data,
	output ebcpu_pkg::state_t  nxt,
	output ebcpu_pkg::result_t res
);
	import ebcpu_pkg::*;

	logic [15:0] imm16;
	logic [1:0]  len;
	logic        jump;
	logic [15:0] target;
	logic [7:0]  b_dec;
	logic [7:0]  c_inc;
	logic [7:0]  c_dec;
	logic [7:0]  c_rl;
	logic [15:0] sp_dec2;

	assign imm16   = {operand_high, operand_low};
	assign b_dec   = cur.bc[15:8] - 8'd1;
	assign c_inc   = cur.bc[7:0] + 8'd1;
	assign c_dec   = cur.bc[7:0] - 8'd1;
	assign c_rl    = {cur.bc[6:0], cur.flags[0]};
	assign sp_dec2 = cur.sp - 16'd2;

	always_comb begin
		nxt    = cur;
		res    = '0;
		len    = 2'd1;
		jump   = 1'b0;
		target = '0;
		if (action == ACT_DELIVER) begin
			case (cur.pend)
				PL_ACC:  nxt.acc = read_data[7:0];
				PL_BC:   nxt.bc  = read_data;
				PL_PC:   nxt.pc  = read_data;
				default: res.status = ST_SEQ_ERR;
			endcase
			nxt.pend = PL_NONE;
		end else if (cur.pend != PL_NONE) begin
			res.status = ST_SEQ_ERR;
		end else begin
			case (opcode)
				OP_NOP: res.cycles = 5'd4;
				OP_LD_BC_NN: begin
					nxt.bc = imm16; len = 2'd3; res.cycles = 5'd12;
				end
				OP_DEC_B: begin
					nxt.bc[15:8] = b_dec;
					nxt.flags = {b_dec == 8'd0, 1'b1, cur.bc[11:8] == 4'd0, cur.flags[0]};
					res.cycles = 5'd4;
				end
				OP_LD_B_N: begin
					nxt.bc[15:8] = operand_low; len = 2'd2; res.cycles = 5'd8;
				end
				OP_INC_C: begin
					nxt.bc[7:0] = c_inc;
					nxt.flags = {c_inc == 8'd0, 1'b0, cur.bc[3:0] == 4'hF, cur.flags[0]};
					res.cycles = 5'd4;
				end
				OP_DEC_C: begin
					nxt.bc[7:0] = c_dec;
					nxt.flags = {c_dec == 8'd0, 1'b1, cur.bc[3:0] == 4'd0, cur.flags[0]};
					res.cycles = 5'd4;
				end
				OP_LD_C_N: begin
					nxt.bc[7:0] = operand_low; len = 2'd2; res.cycles = 5'd8;
				end
				OP_LD_DE_NN: begin
					nxt.de = imm16; len = 2'd3; res.cycles = 5'd12;
				end
				OP_RLA: begin
					nxt.flags = {3'b000, cur.acc[7]};
					nxt.acc = {cur.acc[6:0], cur.flags[0]};
					res.cycles = 5'd4;
				end
				OP_LD_A_DE: begin
					res.mem_kind = MK_RB; res.mem_address = cur.de;
					nxt.pend = PL_ACC; res.cycles = 5'd8;
				end
				OP_JR_NZ: begin
					len = 2'd2;
					if (!cur.flags[3]) begin
						jump = 1'b1;
						target = cur.pc + 16'd2 + {{8{operand_low[7]}}, operand_low};
						res.cycles = 5'd12;
					end else begin
						res.cycles = 5'd8;
					end
				end
				OP_LD_HL_NN: begin
					nxt.hl = imm16; len = 2'd3; res.cycles = 5'd12;
				end
				OP_LDI_HL_A: begin
					res.mem_kind = MK_WB; res.mem_address = cur.hl;
					res.mem_write_data = {8'd0, cur.acc};
					nxt.hl = cur.hl + 16'd1; res.cycles = 5'd8;
				end
				OP_INC_HL: begin
					nxt.hl = cur.hl + 16'd1; res.cycles = 5'd8;
				end
				OP_LDI_A_HL: begin
					res.mem_kind = MK_RB; res.mem_address = cur.hl;
					nxt.pend = PL_ACC; nxt.hl = cur.hl + 16'd1; res.cycles = 5'd8;
				end
				OP_LD_SP_NN: begin
					nxt.sp = imm16; len = 2'd3; res.cycles = 5'd12;
				end
				OP_LDD_HL_A: begin
					res.mem_kind = MK_WB; res.mem_address = cur.hl;
					res.mem_write_data = {8'd0, cur.acc};
					nxt.hl = cur.hl - 16'd1; res.cycles = 5'd8;
				end
				OP_LD_HL_N: begin
					res.mem_kind = MK_WB; res.mem_address = cur.hl;
					res.mem_write_data = {8'd0, operand_low};
					len = 2'd2; res.cycles = 5'd12;
				end
				OP_LD_A_N: begin
					nxt.acc = operand_low; len = 2'd2; res.cycles = 5'd8;
				end
				OP_LD_C_A: begin
					nxt.bc[7:0] = cur.acc; res.cycles = 5'd4;
				end
				OP_LD_HL_A: begin
					res.mem_kind = MK_WB; res.mem_address = cur.hl;
					res.mem_write_data = {8'd0, cur.acc}; res.cycles = 5'd8;
				end
				OP_XOR_A: begin
					nxt.acc = 8'd0; nxt.flags = 4'b1000; res.cycles = 5'd4;
				end
				OP_POP_BC: begin
					res.mem_kind = MK_RW; res.mem_address = cur.sp;
					nxt.pend = PL_BC; nxt.sp = cur.sp + 16'd2; res.cycles = 5'd12;
				end
				OP_JP_NN: begin
					jump = 1'b1; target = imm16; len = 2'd3; res.cycles = 5'd16;
				end
				OP_PUSH_BC: begin
					nxt.sp = sp_dec2;
					res.mem_kind = MK_WW; res.mem_address = sp_dec2;
					res.mem_write_data = cur.bc; res.cycles = 5'd16;
				end
				OP_RET: begin
					res.mem_kind = MK_RW; res.mem_address = cur.sp;
					nxt.pend = PL_PC; nxt.sp = cur.sp + 16'd2; res.cycles = 5'd16;
				end
				PREFIX_CB: begin
					len = 2'd2;
					if (operand_low == CB_RL_C) begin
						nxt.flags = {c_rl == 8'd0, 2'b00, cur.bc[7]};
						nxt.bc[7:0] = c_rl;
						res.cycles = 5'd8;
					end else if (operand_low == CB_BIT7_H) begin
						nxt.flags = {~cur.hl[15], 1'b0, 1'b1, cur.flags[0]};
						res.cycles = 5'd8;
					end else begin
						res.status = ST_BAD_CB;
					end
				end
				OP_CALL_NN: begin
					len = 2'd3;
					nxt.sp = sp_dec2;
					res.mem_kind = MK_WW; res.mem_address = sp_dec2;
					res.mem_write_data = cur.pc + 16'd3;
					jump = 1'b1; target = imm16; res.cycles = 5'd24;
				end
				OP_LDH_N_A: begin
					res.mem_kind = MK_WB; res.mem_address = IO_PAGE | {8'd0, operand_low};
					res.mem_write_data = {8'd0, cur.acc};
					len = 2'd2; res.cycles = 5'd12;
				end
				OP_LD_IOC_A: begin
					res.mem_kind = MK_WB; res.mem_address = IO_PAGE | {8'd0, cur.bc[7:0]};
					res.mem_write_data = {8'd0, cur.acc}; res.cycles = 5'd8;
				end
				OP_LD_NN_A: begin
					res.mem_kind = MK_WB; res.mem_address = imm16;
					res.mem_write_data = {8'd0, cur.acc};
					len = 2'd3; res.cycles = 5'd16;
				end
				OP_LDH_A_N: begin
					res.mem_kind = MK_RB; res.mem_address = IO_PAGE | {8'd0, operand_low};
					nxt.pend = PL_ACC; len = 2'd2; res.cycles = 5'd12;
				end
				OP_DI: begin
					nxt.ie_off = 1'b1; res.cycles = 5'd4;
				end
				OP_CP_N: begin
					nxt.flags = {cur.acc == operand_low, 1'b1,
						cur.acc[3:0] < operand_low[3:0], cur.acc < operand_low};
					len = 2'd2; res.cycles = 5'd8;
				end
				default: res.status = ST_BAD_OP;
			endcase
			if (res.status == ST_OK) begin
				nxt.pc = jump ? target : cur.pc + {14'd0, len};
			end else begin
				// A rejected opcode leaves every register as it was.
				nxt = cur;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/eight_bit_cpu_instruction_step_unit.sv =====
// An accepted beat waits in the item register; its result beat is then held in the result register.
// Throughput: one item beat per cycle, sustained, while results are taken.
// The rate is set by the single execute pass between the item register and result register.
// Reset (arst_n low, asynchronous) zeroes all CPU registers and empties both stages.
`default_nettype none
module eight_bit_cpu_instruction_step_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        action,
	input  logic [7:0]  opcode,
	input  logic [7:0]  operand_low,
	input  logic [7:0]  operand_high,
	input  logic [15:0] read_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  mem_kind,
	output logic [15:0] mem_address,
	output logic [15:0] mem_write_data,
	output logic [15:0] next_pc,
	output logic [4:0]  cycles,
	output logic [1:0]  status,
	output logic [3:0]  flag_bits,
	output logic [7:0]  acc_value,
	output logic        interrupts_disabled
);
	import ebcpu_pkg::*;

	// Item register: the accepted beat waits here for one execute pass.
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  opcode_s1;
	logic [7:0]  operand_low_s1;
	logic [7:0]  operand_high_s1;
	logic [15:0] read_data_s1;

	// Architectural state, advanced once per executed beat.
	state_t  arch_q;
	state_t  arch_next;
	result_t step_res;

	// Result register.
	logic    valid_s2;
	result_t res_s2;
	state_t  view_s2;

	logic advance;

	// The item register moves on whenever the result register is empty or is
	// being drained in this cycle, so a stalled result holds only one beat back.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			action_s1       <= action;
			opcode_s1       <= opcode;
			operand_low_s1  <= operand_low;
			operand_high_s1 <= operand_high;
			read_data_s1    <= read_data;
		end
	end

	ebcpu_exec u_exec (
		.cur          (arch_q),
		.action       (action_s1),
		.opcode       (opcode_s1),
		.operand_low  (operand_low_s1),
		.operand_high (operand_high_s1),
		.read_data    (read_data_s1),
		.nxt          (arch_next),
		.res          (step_res)
	);

	// The state commits at the same edge the result is registered, so the
	// next beat in the item register always sees up-to-date registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '0;
		end else if (advance) begin
			arch_q <= arch_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2  <= step_res;
			view_s2 <= arch_next;
		end
	end

	assign result_valid        = valid_s2;
	assign mem_kind            = res_s2.mem_kind;
	assign mem_address         = res_s2.mem_address;
	assign mem_write_data      = res_s2.mem_write_data;
	assign cycles              = res_s2.cycles;
	assign status              = res_s2.status;
	assign next_pc             = view_s2.pc;
	assign flag_bits           = view_s2.flags;
	assign acc_value           = view_s2.acc;
	assign interrupts_disabled = view_s2.ie_off;

endmodule
`default_nettype wire

// ===== sv/ebcpu_checker.sv =====
`default_nettype none
`include "eight_bit_cpu_instruction_step_unit_defines.svh"
module ebcpu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  mem_kind,
	input logic [15:0] mem_address,
	input logic [15:0] mem_write_data,
	input logic [15:0] next_pc,
	input logic [4:0]  cycles,
	input logic [1:0]  status,
	input logic        interrupts_disabled
);
	import ebcpu_pkg::*;

	// A failed step requests no memory access and costs no cycles.
	`EBCPU_ASSERT_NOW(a_err_quiet, result_valid && status != ST_OK, mem_kind == MK_NONE && cycles == 5'd0, "failed step with memory request or cycles")
	// With no request, address and data read as zero.
	`EBCPU_ASSERT_NOW(a_idle_zero, result_valid && mem_kind == MK_NONE, mem_address == 16'd0 && mem_write_data == 16'd0, "idle request carries address or data")
	// DI is sticky: once reported, every later result keeps it.
	`EBCPU_ASSERT_NEXT(a_di_sticky, result_valid && interrupts_disabled, interrupts_disabled, "interrupt-disable bit cleared")
	// A stalled result beat holds.
	`EBCPU_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(next_pc) && $stable(status), "stalled result changed")

endmodule

bind eight_bit_cpu_instruction_step_unit ebcpu_checker u_ebcpu_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.result_valid        (result_valid),
	.result_ready        (result_ready),
	.mem_kind            (mem_kind),
	.mem_address         (mem_address),
	.mem_write_data      (mem_write_data),
	.next_pc             (next_pc),
	.cycles              (cycles),
	.status              (status),
	.interrupts_disabled (interrupts_disabled)
);
`default_nettype wire
